// ===== design/rpa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpa_pkg
// Shared widths, request and status codes, and controller states for the
// reference-counted page allocator.
// ---------------------------------------------------------------------------
package rpa_pkg;

  localparam int ADDR_W   = 27;  // byte address offset
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int FIRST_W  = 15;  // first_page register
  localparam int REFCNT_W = 8;   // ref_count port
  localparam int FCNT_W   = 16;  // free_count port

  localparam int NUM_PAGES_DEF = 32768;
  localparam int PAGE_BITS_DEF = 12;
  localparam int REF_BITS_DEF  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 3'd0,
    REQ_ALLOC   = 3'd1,
    REQ_FREE    = 3'd2,
    REQ_ADD_REF = 3'd3,
    REQ_DROP_REF = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_FULL     = 3'd3,
    ST_LIMIT    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_EXEC,
    S_INIT
  } state_e;

endpackage

// ===== design/refcounted_page_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// refcounted_page_allocator
// Page allocator with a LIFO free stack of page indices and a per-page
// reference count table, both held in single-port-write synchronous RAMs.
// ---------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  request   | start_i, busy_o           | req_type_i, page_addr_i
//  result    | done_o (one-cycle strobe) | status_o, out_addr_o, released_o,
//            |                           | ref_count_o, free_count_o
//  config    | first_page_we_i           | first_page_i
//
//  Free, add-ref, drop-ref, unknown and empty-stack alloc requests read the
//  count RAM on acceptance, then modify, write back and register the result
//  in the execute state. Alloc from a non-empty stack adds a pop state: the
//  stack RAM read of the top entry comes first, then the count read of that
//  page. Init walks every page.
//  After reset the count RAM is swept to zero with busy_o high. The result
//  strobe shows while the block is idle again, so the next request can be
//  taken in that same cycle; results cannot be held off.
// ---------------------------------------------------------------------------
module refcounted_page_allocator #(
  parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BITS = rpa_pkg::PAGE_BITS_DEF,
  parameter int REF_BITS  = rpa_pkg::REF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rpa_pkg::REQ_W-1:0]     req_type_i,
  input  logic [rpa_pkg::ADDR_W-1:0]    page_addr_i,
  input  logic                          first_page_we_i,
  input  logic [rpa_pkg::FIRST_W-1:0]   first_page_i,
  output logic                          done_o,
  output logic [rpa_pkg::STATUS_W-1:0]  status_o,
  output logic [rpa_pkg::ADDR_W-1:0]    out_addr_o,
  output logic                          released_o,
  output logic [rpa_pkg::REFCNT_W-1:0]  ref_count_o,
  output logic [rpa_pkg::FCNT_W-1:0]    free_count_o
);
  import rpa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);      // page index
  localparam int CW = $clog2(NUM_PAGES + 1);  // stack fill, holds NUM_PAGES
  localparam logic [REF_BITS-1:0] REF_MAX  = '1;
  localparam logic [PW-1:0]       LAST_PG  = PW'(NUM_PAGES - 1);

  // RAMs
  logic [PW-1:0]       free_stack [NUM_PAGES];
  logic [REF_BITS-1:0] ref_table  [NUM_PAGES];

  state_e               state_q, state_d;
  logic [PW-1:0]        cursor_q, cursor_d;
  logic [CW-1:0]        top_q, top_d;
  logic [FIRST_W-1:0]   first_page_q;
  logic [REQ_W-1:0]     req_q, req_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [PW-1:0]        page_q, page_d;
  logic                 popped_q, popped_d;

  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic                 released_q, released_d;
  logic [REFCNT_W-1:0]  ref_count_q, ref_count_d;
  logic [FCNT_W-1:0]    free_count_q, free_count_d;

  logic                 ref_we;
  logic [PW-1:0]        ref_waddr, ref_raddr;
  logic [REF_BITS-1:0]  ref_wdata, ref_rd_q;
  logic                 stk_we;
  logic [PW-1:0]        stk_waddr, stk_wdata, stk_raddr, stk_rd_q;

  logic [31:0]          pg_in, pg_q;
  logic [CW-1:0]        top_m1;
  logic [REF_BITS-1:0]  cnt_inc, cnt_dec;
  logic [63:0]          page_byte;
  logic                 free_bad, ref_bad, stack_full;

  assign pg_in     = 32'(page_addr_i >> PAGE_BITS);
  assign pg_q      = 32'(addr_q >> PAGE_BITS);
  assign top_m1    = top_q - CW'(1);
  assign cnt_inc   = ref_rd_q + REF_BITS'(1);
  assign cnt_dec   = ref_rd_q - REF_BITS'(1);
  assign page_byte = 64'(page_q) << PAGE_BITS;
  assign stack_full = 32'(top_q) >= 32'(NUM_PAGES);
  assign ref_bad   = pg_q >= 32'(NUM_PAGES);
  assign free_bad  = (addr_q[PAGE_BITS-1:0] != '0) || (pg_q < 32'(first_page_q)) || ref_bad;

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    top_d        = top_q;
    req_d        = req_q;
    addr_d       = addr_q;
    page_d       = page_q;
    popped_d     = popped_q;
    done_d       = 1'b0;
    status_d     = status_q;
    out_addr_d   = out_addr_q;
    released_d   = released_q;
    ref_count_d  = ref_count_q;
    free_count_d = free_count_q;
    ref_we       = 1'b0;
    ref_waddr    = cursor_q;
    ref_wdata    = '0;
    ref_raddr    = pg_in[PW-1:0];
    stk_we       = 1'b0;
    stk_waddr    = top_q[PW-1:0];
    stk_wdata    = cursor_q;
    stk_raddr    = top_m1[PW-1:0];

    case (state_q)
      S_CLEAR: begin
        ref_we   = 1'b1;
        cursor_d = cursor_q + PW'(1);
        if (cursor_q == LAST_PG) begin
          cursor_d = '0;
          state_d  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_type_i;
          addr_d   = page_addr_i;
          page_d   = pg_in[PW-1:0];
          popped_d = 1'b0;
          if (req_type_i == REQ_INIT) begin
            cursor_d = '0;
            top_d    = '0;
            state_d  = S_INIT;
          end else if (req_type_i == REQ_ALLOC && top_q != '0) begin
            state_d = S_POP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_POP: begin
        // stack word is here; fetch that page's count
        page_d    = stk_rd_q;
        ref_raddr = stk_rd_q;
        top_d     = top_m1;
        popped_d  = 1'b1;
        state_d   = S_EXEC;
      end
      S_INIT: begin
        ref_we = 1'b1;
        if (32'(cursor_q) >= 32'(first_page_q)) begin
          stk_we = 1'b1;
          top_d  = top_q + CW'(1);
        end
        cursor_d = cursor_q + PW'(1);
        if (cursor_q == LAST_PG) begin
          cursor_d     = '0;
          state_d      = S_IDLE;
          done_d       = 1'b1;
          status_d     = ST_OK;
          out_addr_d   = '0;
          released_d   = 1'b0;
          ref_count_d  = '0;
          free_count_d = FCNT_W'(top_d);
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        status_d    = ST_OK;
        out_addr_d  = '0;
        released_d  = 1'b0;
        ref_count_d = '0;
        ref_waddr   = page_q;
        case (req_q)
          REQ_ALLOC: begin
            if (!popped_q) begin
              status_d = ST_NO_FREE;
            end else begin
              out_addr_d = page_byte[ADDR_W-1:0];
              if (ref_rd_q == REF_MAX) begin
                status_d    = ST_LIMIT;
                ref_count_d = REFCNT_W'(ref_rd_q);
              end else begin
                ref_we      = 1'b1;
                ref_wdata   = cnt_inc;
                ref_count_d = REFCNT_W'(cnt_inc);
              end
            end
          end
          REQ_FREE: begin
            if (free_bad) begin
              status_d = ST_BAD_ADDR;
            end else if (ref_rd_q > REF_BITS'(1)) begin
              ref_we      = 1'b1;
              ref_wdata   = cnt_dec;
              ref_count_d = REFCNT_W'(cnt_dec);
            end else if (stack_full) begin
              status_d    = ST_FULL;
              ref_count_d = REFCNT_W'(ref_rd_q);
            end else begin
              ref_we     = 1'b1;
              ref_wdata  = '0;
              stk_we     = 1'b1;
              stk_wdata  = page_q;
              top_d      = top_q + CW'(1);
              released_d = 1'b1;
            end
          end
          REQ_ADD_REF: begin
            if (ref_bad) begin
              status_d = ST_BAD_ADDR;
            end else if (ref_rd_q == REF_MAX) begin
              status_d    = ST_LIMIT;
              ref_count_d = REFCNT_W'(ref_rd_q);
            end else begin
              ref_we      = 1'b1;
              ref_wdata   = cnt_inc;
              ref_count_d = REFCNT_W'(cnt_inc);
            end
          end
          REQ_DROP_REF: begin
            if (ref_bad) begin
              status_d = ST_BAD_ADDR;
            end else if (ref_rd_q == '0) begin
              status_d = ST_LIMIT;
            end else begin
              ref_we      = 1'b1;
              ref_wdata   = cnt_dec;
              ref_count_d = REFCNT_W'(cnt_dec);
            end
          end
          default: ;  // unknown request: no effect
        endcase
        free_count_d = FCNT_W'(top_d);
      end
      default: state_d = S_IDLE;
    endcase
  end

  // RAMs: one write port each, registered read
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_table[ref_waddr] <= ref_wdata;
    end
    ref_rd_q <= ref_table[ref_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      free_stack[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= free_stack[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cursor_q     <= '0;
      top_q        <= '0;
      first_page_q <= '0;
      popped_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      top_q    <= top_d;
      popped_q <= popped_d;
      done_q   <= done_d;
      if (first_page_we_i) begin
        first_page_q <= first_page_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    addr_q       <= addr_d;
    page_q       <= page_d;
    status_q     <= status_d;
    out_addr_q   <= out_addr_d;
    released_q   <= released_d;
    ref_count_q  <= ref_count_d;
    free_count_q <= free_count_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_addr_o   = out_addr_q;
  assign released_o   = released_q;
  assign ref_count_o  = ref_count_q;
  assign free_count_o = free_count_q;

  // result strobe only follows the execute step or the last init step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_EXEC) || ($past(state_q) == S_INIT))
    else $error("result strobe without a finishing step");

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= 32'(NUM_PAGES))
    else $error("free stack fill beyond capacity");

  a_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && released_q) |-> (status_q == ST_OK) && (ref_count_q == '0))
    else $error("release reported with bad status or count");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (top_q == $past(top_q) - CW'(1)) && popped_q)
    else $error("pop did not take one stack entry");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o && !done_q)
    else $error("accepted request left the controller idle");

endmodule
